/* sv/ils_pkg.sv */
// Shared constants, codes and types of the indexed list store.
`default_nettype none

package ils_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_MAG_W = 7;
    localparam int CMP_W    = (CNT_W > POS_MAG_W) ? CNT_W : POS_MAG_W;

    // Port field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 7;

    localparam logic [DATA_W-1:0] NO_VALUE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_FRONT  = 3'd1,
        OP_BACK   = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } ils_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADOP = 2'd3
    } ils_status_t;

    // Shift command broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] data;
    } ils_shift_t;

endpackage

`default_nettype wire

/* sv/ils_if.sv */
// Valid/ready channel interfaces for operation items and result items.
`default_nettype none

interface ils_in_if;
    logic                             valid;
    logic                             ready;
    logic [ils_pkg::OP_W-1:0]         op;
    logic signed [ils_pkg::POS_W-1:0] position;
    logic signed [ils_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ils_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ils_pkg::DATA_W-1:0] read_value;
    logic [ils_pkg::STATUS_W-1:0]      status;
    logic [ils_pkg::ECNT_W-1:0]        entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

`default_nettype wire

/* sv/ils_cell.sv */
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
`default_nettype none

module ils_cell (
    input  wire logic                        clk,
    input  wire ils_pkg::ils_shift_t         shift,
    input  wire logic [ils_pkg::IDX_W-1:0]   idx,
    input  wire logic [ils_pkg::DATA_W-1:0]  left,
    input  wire logic [ils_pkg::DATA_W-1:0]  right,
    output logic [ils_pkg::DATA_W-1:0]       value
);
    import ils_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    // Take the new word at the slot, the left neighbor behind it on insert,
    // the right neighbor at and behind the slot on delete
    always_comb
    begin
        value_next = value_reg;
        if (shift.ins)
        begin
            if (idx == shift.slot)
            begin
                value_next = shift.data;
            end
            else if (idx > shift.slot)
            begin
                value_next = left;
            end
        end
        else if (shift.del)
        begin
            if (idx >= shift.slot)
            begin
                value_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

/* sv/indexed_list_store_top.sv */
// Top level of the indexed list store: control, entry count and the cell chain.
// Each result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; every cell shifts
// in the same cycle as the operation; a read selects the addressed cell via a mux.
// Reset: the entry count clears to zero and no result is pending; the cells
// themselves are not cleared, and only positions below the count are read.
`default_nettype none

module indexed_list_store_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ils_in_if.sink     in_ch,
    ils_out_if.source  out_ch
);
    import ils_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] rd_value_reg;
    logic [DATA_W-1:0] rd_value_next;
    ils_status_t       status_reg;
    ils_status_t       status_next;

    logic              accept;
    logic              pos_neg;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              is_full;
    logic [IDX_W-1:0]  pos_slot;
    ils_shift_t        shift;
    logic [DATA_W-1:0] cell_q [CAPACITY];

    // Accept a new item whenever the output register is free or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign pos_neg  = in_ch.position[POS_W-1];
    assign pos_ext  = CMP_W'(in_ch.position[POS_MAG_W-1:0]);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign pos_slot = IDX_W'(in_ch.position[POS_MAG_W-1:0]);

    // Decode the operation into a shift command and a result
    always_comb
    begin
        shift.ins     = 1'b0;
        shift.del     = 1'b0;
        shift.slot    = '0;
        shift.data    = in_ch.value;
        count_next    = count_reg;
        rd_value_next = NO_VALUE;
        status_next   = ST_DONE;
        unique case (ils_op_t'(in_ch.op))
            OP_READ:
            begin
                if (pos_neg || (pos_ext >= cnt_ext))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_value_next = cell_q[pos_slot];
                end
            end
            OP_FRONT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    shift.ins  = 1'b1;
                    shift.slot = '0;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    shift.ins  = 1'b1;
                    shift.slot = IDX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (!pos_neg && (pos_ext > cnt_ext))
                begin
                    status_next = ST_RANGE;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    shift.ins  = 1'b1;
                    shift.slot = pos_neg ? '0 : pos_slot;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (pos_neg || (pos_ext >= cnt_ext))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    shift.del  = 1'b1;
                    shift.slot = pos_slot;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_BADOP;
            end
        endcase
        // Hold everything unless an item is taken this cycle
        if (!accept)
        begin
            shift.ins  = 1'b0;
            shift.del  = 1'b0;
            count_next = count_reg;
        end
    end

    // Chain of cells fed by their neighbors, with the input value at the head and itself at the tail
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_q;
        logic [DATA_W-1:0] right_q;

        if (g == 0)
        begin : g_first
            assign left_q = in_ch.value;
        end
        else
        begin : g_mid_l
            assign left_q = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_q = cell_q[g];
        end
        else
        begin : g_mid_r
            assign right_q = cell_q[g+1];
        end

        ils_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .idx   (IDX_W'(g)),
            .left  (left_q),
            .right (right_q),
            .value (cell_q[g])
        );
    end

    // Advance the output register when drained or when a new item lands
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_value_reg <= rd_value_next;
            status_reg   <= status_next;
        end
    end

    logic [ECNT_W-1:0] ecount_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ecount_reg <= ECNT_W'(count_next);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.read_value  = rd_value_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.entry_count = ecount_reg;

endmodule

`default_nettype wire

/* verif/list_store_checker.sv */
// Checker for the indexed list store: predicts each result item and compares it.
module list_store_checker
    import ils_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [OP_W-1:0]          in_op,
    input  logic signed [POS_W-1:0]  in_position,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [DATA_W-1:0]        out_read_value,
    input  logic [STATUS_W-1:0]      out_status,
    input  logic [ECNT_W-1:0]        out_entry_count,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic [ECNT_W-1:0]   entry_count;
    } list_result_t;

    // Shadow copy of the list contents and its fill level
    logic [DATA_W-1:0] cells [CAPACITY];
    int                fill;
    list_result_t      expected_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        fill        = 0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Open a slot and place a value, shifting later entries back
    function automatic void shift_in(input int slot, input logic [DATA_W-1:0] data);
        int i;
        for (i = fill; i > slot; i--)
            cells[i] = cells[i-1];
        cells[slot] = data;
        fill++;
    endfunction

    // Apply one operation to the shadow list and return its result item
    function automatic list_result_t apply_op(input logic [OP_W-1:0] op,
                                              input logic signed [POS_W-1:0] position,
                                              input logic [DATA_W-1:0] data);
        list_result_t res;
        int           pos;
        int           i;
        pos            = int'(position);
        res.read_value = NO_VALUE;
        res.status     = ST_DONE;
        case (op)
            OP_READ:
                if (pos < 0 || pos >= fill)
                    res.status = ST_RANGE;
                else
                    res.read_value = cells[pos];
            OP_FRONT:
                if (fill >= CAPACITY)
                    res.status = ST_FULL;
                else
                    shift_in(0, data);
            OP_BACK:
                if (fill >= CAPACITY)
                    res.status = ST_FULL;
                else
                    shift_in(fill, data);
            OP_INSERT:
                // Range check wins over the full check
                if (pos > fill)
                    res.status = ST_RANGE;
                else if (fill >= CAPACITY)
                    res.status = ST_FULL;
                else
                    shift_in((pos < 0) ? 0 : pos, data);
            OP_DELETE:
                if (pos < 0 || pos >= fill)
                    res.status = ST_RANGE;
                else
                begin
                    for (i = pos; i < fill - 1; i++)
                        cells[i] = cells[i+1];
                    fill--;
                end
            default:
                res.status = ST_BADOP;
        endcase
        res.entry_count = fill[ECNT_W-1:0];
        return res;
    endfunction

    // Compare the result item first, then predict the newly accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            fill        = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result item", out_read_value, NO_VALUE);
                else
                begin
                    list_result_t want;
                    want = expected_results.pop_front();
                    if (out_read_value !== want.read_value)
                        report_mismatch("read_value", out_read_value, want.read_value);
                    if (out_status !== want.status)
                        report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
                    if (out_entry_count !== want.entry_count)
                        report_mismatch("entry_count", DATA_W'(out_entry_count),
                                        DATA_W'(want.entry_count));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_op(in_op, in_position, in_value));
            outstanding = expected_results.size();
        end
    end

endmodule

/* verif/indexed_list_store_top_tb.sv */
// Testbench top for the indexed list store: clock, reset, stimulus and verdict.
module indexed_list_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_PHASE   = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [OP_W-1:0] OP_TOP_CODE = '1;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_CHURN } op_mix_t;

    logic clk;
    logic rst_n;
    logic in_fire;
    int   mismatches;
    int   outstanding;

    ils_in_if  in_ch ();
    ils_out_if out_ch ();

    indexed_list_store_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    list_store_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_op           (in_ch.op),
        .in_position     (in_ch.position),
        .in_value        (in_ch.value),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_read_value  (out_ch.read_value),
        .out_status      (out_ch.status),
        .out_entry_count (out_ch.entry_count),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Record each input handshake for the sender
    always @(posedge clk)
        in_fire <= in_ch.valid && in_ch.ready;

    // Offer one item at the falling edge and hold it until taken
    task automatic offer_item(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] data);
        in_ch.valid    = 1'b1;
        in_ch.op       = op;
        in_ch.position = pos;
        in_ch.value    = data;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_cycles(input int n);
        in_ch.valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Mostly small positions, some across the whole store, a few negative or wild
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return POS_W'($urandom_range(0, 7));
        else if (r < 85)
            return POS_W'($urandom_range(0, CAPACITY + 2));
        else if (r < 95)
            return POS_W'($urandom_range(128, 255));
        return POS_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2: return NO_VALUE;
            3: return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Weight the operations by the current mix
    function automatic logic [OP_W-1:0] pick_op(input op_mix_t mix);
        int r;
        int ins_w;
        int del_w;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin ins_w = 66; del_w = 15; end
            MIX_DRAIN: begin ins_w = 20; del_w = 60; end
            default:   begin ins_w = 40; del_w = 30; end
        endcase
        if (r < 3)
            return OP_W'($urandom_range(int'(OP_DELETE) + 1, int'(OP_TOP_CODE)));
        r = $urandom_range(0, 99);
        if (r < ins_w)
        begin
            case ($urandom_range(0, 2))
                0: return OP_FRONT;
                1: return OP_BACK;
                default: return OP_INSERT;
            endcase
        end
        else if (r < ins_w + del_w)
            return OP_DELETE;
        return OP_READ;
    endfunction

    // Receiver: phases of different stall patterns, one long hold-off
    initial
    begin
        int phase_no;
        int mode;
        int len;
        out_ch.ready = 1'b0;
        phase_no     = 0;
        @(posedge rst_n);
        forever
        begin
            phase_no++;
            if (phase_no == HOLD_PHASE)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    out_ch.ready = 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(1, 60);
                repeat (len)
                begin
                    @(negedge clk);
                    case (mode)
                        0: out_ch.ready = 1'b1;
                        1: out_ch.ready = ($urandom_range(0, 1) == 0);
                        2: out_ch.ready = ($urandom_range(0, 9) != 0);
                        default: out_ch.ready = ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        op_mix_t     mix;
        int          mix_left;
        int          burst_left;
        int          sent;
        logic [OP_W-1:0] c;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_READ;
        in_ch.position = '0;
        in_ch.value    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty store, front and back, positional edges, out-of-range cases, unused op codes
        offer_item(OP_READ, 8'sd0, '0);
        offer_item(OP_READ, -8'sd1, '0);
        offer_item(OP_DELETE, 8'sd0, '0);
        offer_item(OP_INSERT, 8'sd1, 32'h5a5a5a5a);
        offer_item(OP_INSERT, -8'sd128, 32'h12345678);
        offer_item(OP_BACK, 8'sd0, 32'h7fffffff);
        offer_item(OP_FRONT, 8'sd0, 32'h80000000);
        offer_item(OP_INSERT, 8'sd3, NO_VALUE);
        offer_item(OP_INSERT, 8'sd2, '0);
        offer_item(OP_INSERT, 8'sd127, 32'hdeadbeef);
        for (int p = 0; p <= 5; p++)
            offer_item(OP_READ, POS_W'(p), NO_VALUE);
        offer_item(OP_READ, 8'sd127, '0);
        offer_item(OP_READ, -8'sd128, '0);
        offer_item(OP_DELETE, 8'sd2, NO_VALUE);
        offer_item(OP_DELETE, -8'sd1, '0);
        offer_item(OP_DELETE, 8'sd127, '0);
        offer_item(OP_DELETE, 8'sd3, '0);
        for (c = OP_W'(int'(OP_DELETE) + 1); c != '0; c++)
            offer_item(c, -8'sd1, NO_VALUE);
        offer_item(OP_READ, 8'sd0, '0);
        idle_cycles($urandom_range(1, 5));

        // Random: mixes that fill, drain and churn the store, sent in bursts
        sent       = 0;
        mix_left   = 0;
        burst_left = 0;
        mix        = MIX_FILL;
        while (sent < RANDOM_ITEMS)
        begin
            if (mix_left == 0)
            begin
                mix      = op_mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 120);
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 8));
            end
            offer_item(pick_op(mix), pick_position(), pick_value());
            sent++;
            mix_left--;
            burst_left--;
        end
        idle_cycles(0);

        // Drain outstanding results, then allow for the result register
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
